>>> rtl/mast_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and widths for the matrix add/sub/transpose/multiply engine.
// Used by mast_ctrl, mast_dp and matrix_add_sub_transpose_multiply; no dependencies.
package mast_pkg;

  localparam int MAX_DIM  = 8;
  localparam int ELEM_W   = 16;
  localparam int VALUE_W  = 36;
  localparam int IDX_W    = 3;
  localparam int DIM_W    = 4;
  localparam int OP_W     = 3;
  localparam int CMD_W    = 2;
  localparam int REG_W    = 2;
  localparam int CFG_W    = 4;
  localparam int ADDR_C_W = 2 * DIM_W;

  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_TRA = 3'd2;
  localparam logic [OP_W-1:0] OP_TRB = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL = 3'd4;

  localparam logic [REG_W-1:0] REG_OPERATION = 2'd0;
  localparam logic [REG_W-1:0] REG_ROWS_A    = 2'd1;
  localparam logic [REG_W-1:0] REG_COLS_A    = 2'd2;
  localparam logic [REG_W-1:0] REG_COLS_B    = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [ELEM_W-1:0] element;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic             first;
    logic             last_term;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             last;
  } term_tag_t;

  typedef struct packed {
    logic             load_a;
    logic             load_b;
    logic             clr_counts;
    logic             issue;
    logic [OP_W-1:0]  op;
    logic [DIM_W-1:0] cols_a;
    logic [DIM_W-1:0] cols_b;
    logic [DIM_W-1:0] idx_k;
    term_tag_t        tag;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_status_t;

endpackage

>>> rtl/mast_ctrl.sv
`timescale 1ns / 1ps
// Controller: configuration registers, request decode and the emit sequencer
// that walks row, column and inner index. Depends on mast_pkg.
module mast_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mast_pkg::CMD_W-1:0]    in_command,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mast_pkg::REG_W-1:0]    cfg_index,
  input  logic [mast_pkg::CFG_W-1:0]    cfg_data,
  output mast_pkg::dp_cmd_t             cmd,
  input  mast_pkg::dp_status_t          status
);
  import mast_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;

  localparam logic [DIM_W:0] MAXD = (DIM_W + 1)'(MAX_DIM);

  logic [1:0]       state_r, state_nxt;
  logic [OP_W-1:0]  op_r;
  logic [DIM_W-1:0] rows_a_r, cols_a_r, cols_b_r;
  logic [DIM_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DIM_W-1:0] ra, ca, cb, nr, nc, kd;
  logic             accept, op_ok, last_elem, last_k;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if ({1'b0, d} > MAXD) begin
      r = MAXD[DIM_W-1:0];
    end else begin
      r = d;
    end
    return r;
  endfunction

  assign ra = clamp_dim(rows_a_r);
  assign ca = clamp_dim(cols_a_r);
  assign cb = clamp_dim(cols_b_r);

  always_comb begin
    nr = ra;
    nc = ca;
    kd = DIM_W'(1);
    unique case (op_r)
      OP_ADD, OP_SUB: begin
        nr = ra;
        nc = ca;
      end
      OP_TRA, OP_TRB: begin
        nr = ca;
        nc = ra;
      end
      OP_MUL: begin
        nr = ra;
        nc = cb;
        kd = ca;
      end
      default: begin
        nr = ra;
        nc = ca;
      end
    endcase
  end

  assign op_ok     = (op_r <= OP_MUL);
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign last_elem = (i_r == nr - DIM_W'(1)) && (j_r == nc - DIM_W'(1));
  assign last_k    = (k_r == kd - DIM_W'(1));

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.op    = op_r;
    cmd.cols_a = ca;
    cmd.cols_b = cb;
    cmd.idx_k  = k_r;
    cmd.tag.first     = (k_r == '0);
    cmd.tag.last_term = last_k;
    cmd.tag.row       = i_r;
    cmd.tag.col       = j_r;
    cmd.tag.last      = last_elem;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_command)
            CMD_LOAD_A: cmd.load_a = 1'b1;
            CMD_LOAD_B: cmd.load_b = 1'b1;
            CMD_START: begin
              if (op_ok) begin
                i_nxt     = '0;
                j_nxt     = '0;
                k_nxt     = '0;
                state_nxt = S_ISSUE;
              end else begin
                cmd.clr_counts = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (last_k) begin
          k_nxt     = '0;
          state_nxt = S_WAIT;
        end else begin
          k_nxt = k_r + DIM_W'(1);
        end
      end
      S_WAIT: begin
        if (!status.busy) begin
          if (last_elem) begin
            cmd.clr_counts = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_ISSUE;
            if (j_r == nc - DIM_W'(1)) begin
              j_nxt = '0;
              i_nxt = i_r + DIM_W'(1);
            end else begin
              j_nxt = j_r + DIM_W'(1);
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      op_r     <= OP_ADD;
      rows_a_r <= DIM_W'(1);
      cols_a_r <= DIM_W'(1);
      cols_b_r <= DIM_W'(1);
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_OPERATION: op_r     <= cfg_data[OP_W-1:0];
          REG_ROWS_A:    rows_a_r <= cfg_data;
          REG_COLS_A:    cols_a_r <= cfg_data;
          REG_COLS_B:    cols_b_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE) |-> (i_r < nr) && (j_r < nc) && (k_r < kd))
    else $error("emit index beyond result shape");

  a_clr_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_counts |=> (state_r == S_IDLE))
    else $error("load counts cleared mid-sequence");

  a_wait_after_term: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE && last_k) |=> (state_r == S_WAIT) && status.busy)
    else $error("final term not tracked by datapath");

endmodule

>>> rtl/mast_dp.sv
`timescale 1ns / 1ps
// Datapath: A and B element stores with load counters, read stage, term
// stage (add, subtract, pass or multiply), accumulator and output register.
// Depends on mast_pkg.
module mast_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic signed [mast_pkg::ELEM_W-1:0] in_element,
  input  mast_pkg::dp_cmd_t               cmd,
  output mast_pkg::dp_status_t            status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mast_pkg::out_item_t             out_data
);
  import mast_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic signed [ELEM_W-1:0] mem_a [DEPTH];
  logic signed [ELEM_W-1:0] mem_b [DEPTH];

  logic [CW-1:0]            cnt_a_r, cnt_b_r;
  logic [DIM_W-1:0]         a_row, a_col, b_row, b_col, b_stride;
  logic [ADDR_C_W-1:0]      addr_a_full, addr_b_full;
  logic [AW-1:0]            addr_a, addr_b;
  logic signed [ELEM_W-1:0] rd_a_r, rd_b_r;
  logic                     v1_r, v2_r, acc_full_r, out_valid_r;
  term_tag_t                tag1_r, tag2_r, acc_tag_r;
  logic signed [VALUE_W-1:0] ext_a, ext_b, term_nxt, term_r, acc_r;
  logic signed [2*ELEM_W-1:0] prod;
  out_item_t                out_r;
  logic                     xfer;

  always_comb begin
    a_row    = cmd.tag.row;
    a_col    = cmd.tag.col;
    b_row    = cmd.tag.row;
    b_col    = cmd.tag.col;
    b_stride = cmd.cols_a;
    unique case (cmd.op)
      OP_TRA: begin
        a_row = cmd.tag.col;
        a_col = cmd.tag.row;
      end
      OP_TRB: begin
        b_row = cmd.tag.col;
        b_col = cmd.tag.row;
      end
      OP_MUL: begin
        a_col    = cmd.idx_k;
        b_row    = cmd.idx_k;
        b_stride = cmd.cols_b;
      end
      default: ;
    endcase
  end

  assign addr_a_full = ADDR_C_W'(a_row) * ADDR_C_W'(cmd.cols_a) + ADDR_C_W'(a_col);
  assign addr_b_full = ADDR_C_W'(b_row) * ADDR_C_W'(b_stride) + ADDR_C_W'(b_col);
  assign addr_a      = addr_a_full[AW-1:0];
  assign addr_b      = addr_b_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_a && (cnt_a_r < CW'(DEPTH))) begin
      mem_a[cnt_a_r[AW-1:0]] <= in_element;
    end
    if (cmd.issue) begin
      rd_a_r <= mem_a[addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_b && (cnt_b_r < CW'(DEPTH))) begin
      mem_b[cnt_b_r[AW-1:0]] <= in_element;
    end
    if (cmd.issue) begin
      rd_b_r <= mem_b[addr_b];
    end
  end

  assign ext_a = {{(VALUE_W - ELEM_W){rd_a_r[ELEM_W-1]}}, rd_a_r};
  assign ext_b = {{(VALUE_W - ELEM_W){rd_b_r[ELEM_W-1]}}, rd_b_r};
  assign prod  = rd_a_r * rd_b_r;

  always_comb begin
    case (cmd.op)
      OP_ADD:  term_nxt = ext_a + ext_b;
      OP_SUB:  term_nxt = ext_a - ext_b;
      OP_TRA:  term_nxt = ext_a;
      OP_TRB:  term_nxt = ext_b;
      OP_MUL:  term_nxt = {{(VALUE_W - 2*ELEM_W){prod[2*ELEM_W-1]}}, prod};
      default: term_nxt = ext_a;
    endcase
  end

  assign xfer = acc_full_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    tag1_r <= cmd.tag;
    if (v1_r) begin
      term_r <= term_nxt;
      tag2_r <= tag1_r;
    end
    if (v2_r) begin
      acc_r     <= tag2_r.first ? term_r : acc_r + term_r;
      acc_tag_r <= tag2_r;
    end
    if (xfer) begin
      out_r.value <= acc_r;
      out_r.row   <= acc_tag_r.row[IDX_W-1:0];
      out_r.col   <= acc_tag_r.col[IDX_W-1:0];
      out_r.last  <= acc_tag_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      acc_full_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_counts) begin
        cnt_a_r <= '0;
        cnt_b_r <= '0;
      end else begin
        if (cmd.load_a && (cnt_a_r < CW'(DEPTH))) begin
          cnt_a_r <= cnt_a_r + CW'(1);
        end
        if (cmd.load_b && (cnt_b_r < CW'(DEPTH))) begin
          cnt_b_r <= cnt_b_r + CW'(1);
        end
      end
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (v2_r && tag2_r.last_term) begin
        acc_full_r <= 1'b1;
      end else if (xfer) begin
        acc_full_r <= 1'b0;
      end
      if (xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.busy = cmd.issue || v1_r || v2_r || acc_full_r;
  assign out_valid   = out_valid_r;
  assign out_data    = out_r;

  a_no_issue_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !acc_full_r)
    else $error("new term issued over a pending result");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_full_r && !xfer) |=> acc_full_r && $stable(acc_r))
    else $error("pending result lost");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CW'(DEPTH)) && (cnt_b_r <= CW'(DEPTH)))
    else $error("load count beyond store depth");

endmodule

>>> rtl/matrix_add_sub_transpose_multiply.sv
`timescale 1ns / 1ps
// Matrix engine top: load requests fill stores A and B, a start request emits
// the chosen result matrix row by row. Depends on mast_pkg, mast_ctrl, mast_dp.
// Load requests are accepted only while no start is running. Start: for each result
// element the controller issues K terms (K = cols_a for multiply, 1 otherwise) through
// one read port per store, then waits for the read, term and accumulate stages and the
// handoff to the output register before the next element; the output handshake can hold that handoff.
// Reset: operation add, dimensions 1, load counts zero; stores are not cleared.
module matrix_add_sub_transpose_multiply (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mast_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mast_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mast_pkg::REG_W-1:0] cfg_index,
  input  logic [mast_pkg::CFG_W-1:0] cfg_data
);
  import mast_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mast_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_command(in_data.command),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

  mast_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_element(in_data.element),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> verif/tb_matrix_add_sub_transpose_multiply.sv
`timescale 1ns / 1ps
// Testbench for matrix_add_sub_transpose_multiply: load, start and register write requests with
// random idling on both channels; each result element is checked against a scoreboard.
// Depends on mast_pkg and the matrix_add_sub_transpose_multiply RTL.
module tb_matrix_add_sub_transpose_multiply;
  import mast_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int IDLE_PCT = 31;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 220;
  localparam int MAX_REPORTS = 40;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam logic [OP_W-1:0] OP_NONE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_NONE_HI = 3'd7;

  class matrix_scoreboard;
    logic signed [ELEM_W-1:0] mem_a [DEPTH];
    logic signed [ELEM_W-1:0] mem_b [DEPTH];
    int unsigned fill_a;
    int unsigned fill_b;
    logic [OP_W-1:0] op;
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] cols_a;
    logic [DIM_W-1:0] cols_b;
    out_item_t pending_elems [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned requests;
    int unsigned starts;
    int unsigned cfg_writes;

    function new();
      foreach (mem_a[s]) begin
        mem_a[s] = '0;
        mem_b[s] = '0;
      end
      fill_a = 0;
      fill_b = 0;
      op = OP_ADD;
      rows_a = 1;
      cols_a = 1;
      cols_b = 1;
      errors = 0;
      checked = 0;
      requests = 0;
      starts = 0;
      cfg_writes = 0;
    endfunction

    static function int unsigned dim(logic [DIM_W-1:0] d);
      if (d == 0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return d;
    endfunction

    function void write_reg(logic [REG_W-1:0] idx, logic [CFG_W-1:0] data);
      cfg_writes++;
      case (idx)
        REG_OPERATION: op = data[OP_W-1:0];
        REG_ROWS_A:    rows_a = data;
        REG_COLS_A:    cols_a = data;
        REG_COLS_B:    cols_b = data;
        default: ;
      endcase
    endfunction

    function void emit_matrix();
      int unsigned ra, ca, cb, nr, nc;
      int unsigned i, j, k;
      longint acc;
      out_item_t elem;
      ra = dim(rows_a);
      ca = dim(cols_a);
      cb = dim(cols_b);
      case (op)
        OP_ADD, OP_SUB: begin
          nr = ra;
          nc = ca;
        end
        OP_TRA, OP_TRB: begin
          nr = ca;
          nc = ra;
        end
        OP_MUL: begin
          nr = ra;
          nc = cb;
        end
        default: begin
          nr = 0;
          nc = 0;
        end
      endcase
      for (i = 0; i < nr; i++) begin
        for (j = 0; j < nc; j++) begin
          acc = 0;
          case (op)
            OP_ADD: acc = longint'(mem_a[i*ca+j]) + longint'(mem_b[i*ca+j]);
            OP_SUB: acc = longint'(mem_a[i*ca+j]) - longint'(mem_b[i*ca+j]);
            OP_TRA: acc = longint'(mem_a[j*ca+i]);
            OP_TRB: acc = longint'(mem_b[j*ca+i]);
            default: begin
              for (k = 0; k < ca; k++)
                acc += longint'(mem_a[i*ca+k]) * longint'(mem_b[k*cb+j]);
            end
          endcase
          elem.value = acc[VALUE_W-1:0];
          elem.row = i[IDX_W-1:0];
          elem.col = j[IDX_W-1:0];
          elem.last = (i == nr - 1) && (j == nc - 1);
          pending_elems.push_back(elem);
        end
      end
    endfunction

    function void note_request(in_item_t req);
      requests++;
      case (req.command)
        CMD_LOAD_A: begin
          if (fill_a < DEPTH) begin
            mem_a[fill_a] = req.element;
            fill_a++;
          end
        end
        CMD_LOAD_B: begin
          if (fill_b < DEPTH) begin
            mem_b[fill_b] = req.element;
            fill_b++;
          end
        end
        CMD_START: begin
          emit_matrix();
          fill_a = 0;
          fill_b = 0;
          starts++;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endtask

    task check_element(out_item_t got);
      out_item_t want;
      if (pending_elems.size() == 0) begin
        report($sformatf("unexpected element row %0d col %0d value %0d",
                         got.row, got.col, got.value));
        return;
      end
      want = pending_elems.pop_front();
      checked++;
      if (got.value !== want.value)
        report($sformatf("element %0d value %0d, want %0d", checked, got.value, want.value));
      if (got.row !== want.row)
        report($sformatf("element %0d row %0d, want %0d", checked, got.row, want.row));
      if (got.col !== want.col)
        report($sformatf("element %0d col %0d, want %0d", checked, got.col, want.col));
      if (got.last !== want.last)
        report($sformatf("element %0d last %0b, want %0b", checked, got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  bit quiet = 1'b0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned gen_fill_a = 0;
  int unsigned gen_fill_b = 0;
  bit written_a [DEPTH];
  bit written_b [DEPTH];
  matrix_scoreboard board = new();

  matrix_add_sub_transpose_multiply dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  always @(posedge clk) out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) board.note_request(in_data);
      if (out_valid && out_ready) board.check_element(out_data);
    end
  end

  function automatic logic signed [ELEM_W-1:0] pick_element();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return -16'sd1;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return DIM_W'($urandom_range(3, 1));
    if (r < 88) return DIM_W'($urandom_range(MAX_DIM, 4));
    if (r < 94) return '0;
    return DIM_W'($urandom_range(15, MAX_DIM + 1));
  endfunction

  function automatic logic [OP_W-1:0] rand_op();
    if ($urandom_range(9) == 0) return OP_W'($urandom_range(OP_NONE_HI, OP_NONE_LO));
    return OP_W'($urandom_range(OP_MUL, OP_ADD));
  endfunction

  // fewest loads that leave no unwritten slot below need
  function automatic int unsigned min_loads(bit to_b, int unsigned need);
    int unsigned n;
    int unsigned s;
    n = 0;
    for (s = 0; s < need; s++)
      if (!(to_b ? written_b[s] : written_a[s])) n = s + 1;
    return n;
  endfunction

  task automatic send_request(logic [CMD_W-1:0] cmd, logic signed [ELEM_W-1:0] elem);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= in_item_t'{command: cmd, element: elem};
    do @(posedge clk); while (!in_ready);
    if (cmd != CMD_NOP) items_sent++;
  endtask

  task automatic load_elem(bit to_b, logic signed [ELEM_W-1:0] elem);
    if (!to_b) begin
      if (gen_fill_a < DEPTH) begin
        written_a[gen_fill_a] = 1'b1;
        gen_fill_a++;
      end
      send_request(CMD_LOAD_A, elem);
    end else begin
      if (gen_fill_b < DEPTH) begin
        written_b[gen_fill_b] = 1'b1;
        gen_fill_b++;
      end
      send_request(CMD_LOAD_B, elem);
    end
  endtask

  task automatic issue_start();
    send_request(CMD_START, ELEM_W'($urandom));
    gen_fill_a = 0;
    gen_fill_b = 0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_elems.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [OP_W-1:0] op, logic [DIM_W-1:0] ra,
                            logic [DIM_W-1:0] ca, logic [DIM_W-1:0] cb);
    logic [CFG_W-1:0] vals [4];
    logic [REG_W-1:0] regs [4];
    int r;
    wait_drained();
    regs[0] = REG_OPERATION;
    regs[1] = REG_ROWS_A;
    regs[2] = REG_COLS_A;
    regs[3] = REG_COLS_B;
    vals[0] = {1'($urandom_range(1)), op};
    vals[1] = ra;
    vals[2] = ca;
    vals[3] = cb;
    for (r = 0; r < 4; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data <= vals[r];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_job(logic [OP_W-1:0] op, logic [DIM_W-1:0] ra, logic [DIM_W-1:0] ca,
                         logic [DIM_W-1:0] cb, bit broken, int unsigned extra);
    int unsigned era, eca, ecb, need_a, need_b, left_a, left_b;
    set_config(op, ra, ca, cb);
    era = matrix_scoreboard::dim(ra);
    eca = matrix_scoreboard::dim(ca);
    ecb = matrix_scoreboard::dim(cb);
    need_a = 0;
    need_b = 0;
    case (op)
      OP_ADD, OP_SUB: begin
        need_a = era * eca;
        need_b = era * eca;
      end
      OP_TRA: need_a = era * eca;
      OP_TRB: need_b = era * eca;
      OP_MUL: begin
        need_a = era * eca;
        need_b = eca * ecb;
      end
      default: ;
    endcase
    left_a = broken ? $urandom_range(need_a + 3, min_loads(1'b0, need_a)) : need_a;
    left_b = broken ? $urandom_range(need_b + 3, min_loads(1'b1, need_b)) : need_b;
    left_a += extra;
    while (left_a + left_b > 0) begin
      if ($urandom_range(99) < 4) send_request(CMD_NOP, pick_element());
      if (left_b == 0 || (left_a != 0 && $urandom_range(1) == 0)) begin
        load_elem(1'b0, pick_element());
        left_a--;
      end else begin
        load_elem(1'b1, pick_element());
        left_b--;
      end
    end
    issue_start();
  endtask

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned rand_base;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 2x2 extremes, then every operation, invalid operation codes and zero dimensions on the same stores
    set_config(OP_ADD, 4'd2, 4'd2, 4'd2);
    load_elem(1'b0, 16'sh7fff);
    load_elem(1'b0, 16'sh8000);
    load_elem(1'b0, 16'sh8000);
    load_elem(1'b0, 16'sh7fff);
    load_elem(1'b1, 16'sh8000);
    load_elem(1'b1, 16'sh8000);
    load_elem(1'b1, 16'sh7fff);
    load_elem(1'b1, -16'sd1);
    issue_start();
    set_config(OP_SUB, 4'd2, 4'd2, 4'd2);
    issue_start();
    set_config(OP_TRA, 4'd2, 4'd2, 4'd2);
    issue_start();
    set_config(OP_TRB, 4'd2, 4'd2, 4'd2);
    issue_start();
    set_config(OP_MUL, 4'd2, 4'd2, 4'd2);
    issue_start();
    set_config(OP_NONE_LO, 4'd2, 4'd2, 4'd2);
    issue_start();
    set_config(OP_NONE_HI, 4'd2, 4'd2, 4'd2);
    send_request(CMD_NOP, 16'sh5a5a);
    issue_start();
    set_config(OP_ADD, 4'd0, 4'd0, 4'd0);
    issue_start();
    set_config(OP_MUL, 4'd2, 4'd0, 4'd0);
    issue_start();

    // no idling: overfill store A, then oversized dimension codes; then random jobs
    rand_base = items_sent;
    quiet = 1'b1;
    run_job(OP_TRA, 4'd8, 4'd8, 4'd1, 1'b0, 3);
    run_job(OP_MUL, 4'd15, 4'd1, 4'd9, 1'b0, 0);
    while (items_sent - rand_base < RANDOM_ITEMS) begin
      quiet = ($urandom_range(9) == 0);
      run_job(rand_op(), rand_dim(), rand_dim(), rand_dim(), $urandom_range(99) < 15, 0);
    end
    quiet = 1'b0;
    wait_drained();

    if (board.pending_elems.size() != 0)
      board.report($sformatf("%0d elements never arrived", board.pending_elems.size()));
    $display("covered %0d requests, %0d starts, %0d register writes",
             board.requests, board.starts, board.cfg_writes);
    $display("compared %0d result elements, %0d mismatches", board.checked, board.errors);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
